/* src/kperm_pkg.sv */
// Shared types and constants for the k-permutation generator.
package kperm_pkg;

   localparam int VAL_W      = 4;
   localparam int NUM_POS    = 8;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 4;

   localparam logic [VAL_W-1:0] COUNT_RESET = 4'd8;

   typedef logic [VAL_W-1:0] val_type;

   // scan moves toward position 0, fill moves toward the last position
   typedef struct packed {
      logic scan;
      logic fill;
   } tok_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_VALUE_COUNT = 1'b0,
      REG_PICK_COUNT  = 1'b1
   } csr_reg_type;

endpackage

/* src/kperm_req_if.sv */
// Request channel: valid/ready handshake carrying the restart bit.
interface kperm_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink   (input valid, input restart, output ready);
endinterface

/* src/kperm_rsp_if.sv */
// Response channel: valid/ready handshake carrying one selection item.
interface kperm_rsp_if;
   logic                 valid;
   logic                 ready;
   kperm_pkg::val_type   pos0;
   kperm_pkg::val_type   pos1;
   kperm_pkg::val_type   pos2;
   kperm_pkg::val_type   pos3;
   kperm_pkg::val_type   pos4;
   kperm_pkg::val_type   pos5;
   kperm_pkg::val_type   pos6;
   kperm_pkg::val_type   pos7;
   logic                 is_final;
   logic                 exhausted;

   modport source (output valid, output pos0, output pos1, output pos2, output pos3,
                   output pos4, output pos5, output pos6, output pos7,
                   output is_final, output exhausted, input ready);
   modport sink   (input valid, input pos0, input pos1, input pos2, input pos3,
                   input pos4, input pos5, input pos6, input pos7,
                   input is_final, input exhausted, output ready);
endinterface

/* src/kperm_cell.sv */
// One selection position: holds its value and advances or refills it on a token.
module kperm_cell #(
   parameter int MAX_N = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  kperm_pkg::val_type n_val,
   input  kperm_pkg::tok_type tok_in,
   input  logic [MAX_N-1:0]   mask_in,
   output kperm_pkg::val_type value,
   output kperm_pkg::tok_type tok_out,
   output logic [MAX_N-1:0]   mask_out
);

   kperm_pkg::tok_type tok_ff;
   logic [MAX_N-1:0]   mask_ff;
   kperm_pkg::val_type value_ff;
   kperm_pkg::val_type value_in;

   logic [MAX_N-1:0]   cur_bit;
   logic [MAX_N-1:0]   above;
   logic [MAX_N-1:0]   le_n;
   logic [MAX_N-1:0]   rel;
   logic [MAX_N-1:0]   base;
   logic [MAX_N-1:0]   cand;
   logic [MAX_N-1:0]   pick_bit;
   kperm_pkg::val_type pick;
   logic               found;

   always_comb begin
      for (int k = 0; k < MAX_N; k++) begin
         cur_bit[k] = (4'(k + 1) == value_ff);
         above[k]   = (4'(k) >= value_ff);
         le_n[k]    = (4'(k) < n_val);
      end
      rel      = mask_ff & ~cur_bit;
      base     = tok_ff.scan ? rel : mask_ff;
      cand     = tok_ff.scan ? (~rel & above & le_n) : (~mask_ff & le_n);
      found    = |cand;
      pick_bit = cand & (~cand + 1'b1);
      pick     = '0;
      for (int k = MAX_N - 1; k >= 0; k--) begin
         if (cand[k]) begin
            pick = 4'(k + 1);
         end
      end
      tok_out.scan = tok_ff.scan && !found;
      tok_out.fill = (tok_ff.scan || tok_ff.fill) && found;
      mask_out     = tok_out.fill ? (base | pick_bit) : base;
      value_in     = tok_out.fill ? pick : value_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in;
      end
      mask_ff  <= mask_in;
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

/* src/k_permutation_lex_generator_core.sv */
// k-permutation generator top: row of position cells plus request sequencer.
//
// Each request item returns the next ordered selection of m distinct values from 1..n in
// lexicographic order (restart=1 begins again at 1..m). A row of MAX_N position cells
// computes the successor by passing a token with the used-value mask from cell to cell, one
// cell per cycle: a scan token walks left from position m-1 until a cell can take a larger
// free value, then a fill token walks right giving each later position the smallest free
// value. A restart or next-selection request runs the token walk before its response is
// registered; one with bad counts or past the final selection skips it. One item is in work
// at a time. Writing either register makes the next request return the first selection.
module k_permutation_lex_generator_core #(
   parameter int MAX_N = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   kperm_req_if.sink                          req,
   kperm_rsp_if.source                        rsp,
   input  logic                               csr_wr_en,
   input  logic [kperm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [kperm_pkg::CSR_DATA_W-1:0]   csr_wr_data
);

   localparam kperm_pkg::val_type MAX_V = 4'(MAX_N);

   typedef enum logic [1:0] {
      S_IDLE,
      S_RUN,
      S_LAST
   } state_type;

   state_type           state_ff;
   kperm_pkg::val_type  value_count_ff;
   kperm_pkg::val_type  pick_count_ff;
   logic                started_ff;
   logic                finished_ff;
   logic                exh_ff;
   logic [MAX_N-1:0]    used_ff;
   logic                rsp_valid_ff;
   kperm_pkg::val_type  pos_ff [kperm_pkg::NUM_POS];
   logic                is_final_ff;
   logic                exhausted_ff;

   kperm_pkg::val_type  n_val;
   kperm_pkg::val_type  m_val;
   logic                accept;
   logic                bad;
   logic                first;
   logic                inject_fill;
   logic                inject_scan;
   logic                done;
   logic                fail;
   logic                last;
   logic [MAX_N-1:0]    done_mask;

   kperm_pkg::tok_type  tok_in   [MAX_N];
   kperm_pkg::tok_type  tok_out  [MAX_N];
   logic [MAX_N-1:0]    mask_in  [MAX_N];
   logic [MAX_N-1:0]    mask_out [MAX_N];
   kperm_pkg::val_type  cell_val [MAX_N];
   kperm_pkg::val_type  pos_val  [kperm_pkg::NUM_POS];

   assign n_val = (value_count_ff > MAX_V) ? MAX_V : value_count_ff;
   assign m_val = (pick_count_ff > MAX_V) ? MAX_V : pick_count_ff;

   assign req.ready   = (state_ff == S_IDLE);
   assign accept      = req.valid && req.ready;
   assign bad         = (m_val == 4'd0) || (m_val > n_val);
   assign first       = req.restart || !started_ff;
   assign inject_fill = accept && !bad && first;
   assign inject_scan = accept && !bad && !first && !finished_ff;

   for (genvar i = 0; i < MAX_N; i++) begin : g_cell
      logic from_right;
      logic from_left;

      if (i < MAX_N - 1) begin : g_r
         assign from_right = tok_out[i+1].scan;
      end else begin : g_rn
         assign from_right = 1'b0;
      end

      if (i > 0) begin : g_l
         assign from_left = tok_out[i-1].fill && (4'(i) < m_val);
      end else begin : g_ln
         assign from_left = 1'b0;
      end

      always_comb begin
         tok_in[i].scan = from_right || (inject_scan && (4'(i + 1) == m_val));
         tok_in[i].fill = from_left || (inject_fill && (i == 0));
         if (from_right) begin
            mask_in[i] = mask_out[(i < MAX_N - 1) ? i + 1 : i];
         end else if (from_left) begin
            mask_in[i] = mask_out[(i > 0) ? i - 1 : i];
         end else if (inject_fill) begin
            mask_in[i] = '0;
         end else begin
            mask_in[i] = used_ff;
         end
      end

      kperm_cell #(
         .MAX_N (MAX_N)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .n_val    (n_val),
         .tok_in   (tok_in[i]),
         .mask_in  (mask_in[i]),
         .value    (cell_val[i]),
         .tok_out  (tok_out[i]),
         .mask_out (mask_out[i])
      );
   end

   for (genvar j = 0; j < kperm_pkg::NUM_POS; j++) begin : g_pos
      if (j < MAX_N) begin : g_used
         assign pos_val[j] = (4'(j) < m_val) ? cell_val[j] : 4'd0;
      end else begin : g_zero
         assign pos_val[j] = 4'd0;
      end
   end

   always_comb begin
      done      = 1'b0;
      done_mask = '0;
      last      = 1'b1;
      for (int i = 0; i < MAX_N; i++) begin
         if (tok_out[i].fill && (4'(i + 1) == m_val)) begin
            done      = 1'b1;
            done_mask = mask_out[i];
         end
         if ((4'(i) < m_val) && (cell_val[i] != (n_val - 4'(i)))) begin
            last = 1'b0;
         end
      end
      fail = tok_out[0].scan;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         value_count_ff <= kperm_pkg::COUNT_RESET;
         pick_count_ff  <= kperm_pkg::COUNT_RESET;
         started_ff     <= 1'b0;
         finished_ff    <= 1'b0;
         exh_ff         <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp.ready && (state_ff != S_LAST)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  if (bad || (!first && finished_ff)) begin
                     exh_ff      <= 1'b1;
                     started_ff  <= 1'b1;
                     finished_ff <= 1'b1;
                     state_ff    <= S_LAST;
                  end else begin
                     exh_ff     <= 1'b0;
                     started_ff <= 1'b1;
                     if (first) begin
                        finished_ff <= 1'b0;
                     end
                     state_ff <= S_RUN;
                  end
               end
            end
            S_RUN: begin
               if (fail) begin
                  exh_ff      <= 1'b1;
                  finished_ff <= 1'b1;
                  state_ff    <= S_LAST;
               end else if (done) begin
                  used_ff  <= done_mask;
                  state_ff <= S_LAST;
               end
            end
            S_LAST: begin
               if (!rsp_valid_ff || rsp.ready) begin
                  rsp_valid_ff <= 1'b1;
                  for (int j = 0; j < kperm_pkg::NUM_POS; j++) begin
                     pos_ff[j] <= exh_ff ? 4'd0 : pos_val[j];
                  end
                  is_final_ff  <= !exh_ff && last;
                  exhausted_ff <= exh_ff;
                  if (!exh_ff) begin
                     finished_ff <= last;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
         if (csr_wr_en) begin
            case (csr_index)
               kperm_pkg::REG_VALUE_COUNT: begin
                  value_count_ff <= csr_wr_data;
                  started_ff     <= 1'b0;
                  finished_ff    <= 1'b0;
               end
               kperm_pkg::REG_PICK_COUNT: begin
                  pick_count_ff <= csr_wr_data;
                  started_ff    <= 1'b0;
                  finished_ff   <= 1'b0;
               end
               default: begin
               end
            endcase
         end
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.pos0      = pos_ff[0];
   assign rsp.pos1      = pos_ff[1];
   assign rsp.pos2      = pos_ff[2];
   assign rsp.pos3      = pos_ff[3];
   assign rsp.pos4      = pos_ff[4];
   assign rsp.pos5      = pos_ff[5];
   assign rsp.pos6      = pos_ff[6];
   assign rsp.pos7      = pos_ff[7];
   assign rsp.is_final  = is_final_ff;
   assign rsp.exhausted = exhausted_ff;

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the k-permutation generator: paced requests, predicted items.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic        restart;
      int unsigned gap;
   } req_item_type;

   typedef struct packed {
      kperm_pkg::val_type [kperm_pkg::NUM_POS-1:0] pos;
      logic                                        is_final;
      logic                                        exhausted;
   } selection_type;

   localparam int unsigned RANDOM_ITEMS = 1550;

   logic                             clock;
   logic                             reset;
   logic                             csr_wr_en;
   logic [kperm_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [kperm_pkg::CSR_DATA_W-1:0] csr_wr_data;

   kperm_req_if req_if ();
   kperm_rsp_if rsp_if ();

   k_permutation_lex_generator_core #(.MAX_N(kperm_pkg::NUM_POS)) u_top (
      .clock       (clock),
      .reset       (reset),
      .req         (req_if),
      .rsp         (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // predictor state
   kperm_pkg::val_type sel_state [kperm_pkg::NUM_POS];
   logic [15:0]        used_mask;
   logic               have_started;
   logic               at_last;
   logic [3:0]         n_reg;
   logic [3:0]         m_reg;

   req_item_type   pending_requests [$];
   selection_type  expected_selections [$];

   int unsigned issued_cnt   = 0;
   int unsigned taken_cnt    = 0;
   int unsigned rsp_cnt      = 0;
   int unsigned mismatches   = 0;
   int unsigned n_final      = 0;
   int unsigned n_exhausted  = 0;
   int unsigned n_restarts   = 0;
   int unsigned n_writes     = 0;
   int unsigned random_items = 0;
   logic        req_burst    = 1'b0;
   logic        rsp_burst    = 1'b0;

   function automatic logic [15:0] value_bit(int unsigned v);
      return (v >= 1 && v <= 15) ? (16'd1 << (v - 1)) : 16'd0;
   endfunction

   // smallest free values, ascending, from position first on
   function automatic void fill_from(int unsigned first, int unsigned n, int unsigned m);
      int unsigned v;
      for (int unsigned p = first; p < m && p < kperm_pkg::NUM_POS; p++) begin
         v = 1;
         while (v <= n && (used_mask & value_bit(v)) != 0) v++;
         sel_state[p] = kperm_pkg::val_type'(v);
         used_mask |= value_bit(v);
      end
   endfunction

   function automatic logic advance_sel(int unsigned n, int unsigned m);
      int unsigned i;
      int unsigned cur;
      i = m;
      while (i > 0) begin
         i--;
         cur = sel_state[i];
         used_mask &= ~value_bit(cur);
         for (int unsigned v = cur + 1; v <= n; v++) begin
            if ((used_mask & value_bit(v)) == 0) begin
               sel_state[i] = kperm_pkg::val_type'(v);
               used_mask |= value_bit(v);
               fill_from(i + 1, n, m);
               return 1'b1;
            end
         end
      end
      return 1'b0;
   endfunction

   function automatic selection_type next_selection(logic restart);
      selection_type r;
      int unsigned   n;
      int unsigned   m;
      logic          ok;
      n = (n_reg > kperm_pkg::NUM_POS) ? kperm_pkg::NUM_POS : n_reg;
      m = (m_reg > kperm_pkg::NUM_POS) ? kperm_pkg::NUM_POS : m_reg;
      r = '0;
      if (m == 0 || m > n) begin
         ok = 1'b0;
      end else if (restart || !have_started) begin
         foreach (sel_state[j]) sel_state[j] = '0;
         used_mask = '0;
         fill_from(0, n, m);
         ok = 1'b1;
      end else if (at_last) begin
         ok = 1'b0;
      end else begin
         ok = advance_sel(n, m);
      end
      have_started = 1'b1;
      if (!ok) begin
         at_last = 1'b1;
         r.exhausted = 1'b1;
         return r;
      end
      r.is_final = 1'b1;
      for (int unsigned j = 0; j < m; j++) begin
         r.pos[j] = sel_state[j];
         if (sel_state[j] != kperm_pkg::val_type'(n - j)) r.is_final = 1'b0;
      end
      at_last = r.is_final;
      return r;
   endfunction

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1_500_000;
      $display("timeout: %0d items issued, %0d responses outstanding",
               issued_cnt, expected_selections.size());
      $display("RESULT: ERROR");
      $finish;
   end

   // request driver
   always @(negedge clock) begin : drive_req
      int unsigned gap_left;
      logic        gap_armed;
      if (reset) begin
         req_if.valid   <= 1'b0;
         req_if.restart <= 1'b0;
         gap_armed = 1'b0;
         gap_left  = 0;
      end else if (taken_cnt == issued_cnt) begin
         if (pending_requests.size() == 0) begin
            req_if.valid <= 1'b0;
         end else begin
            if (!gap_armed) begin
               gap_left  = pending_requests[0].gap;
               gap_armed = 1'b1;
            end
            if (gap_left > 0) begin
               gap_left--;
               req_if.valid <= 1'b0;
            end else begin
               req_if.restart <= pending_requests[0].restart;
               req_if.valid   <= 1'b1;
               void'(pending_requests.pop_front());
               gap_armed = 1'b0;
               issued_cnt++;
            end
         end
      end
   end

   // response back-pressure
   always @(negedge clock) begin : drive_rsp_ready
      int unsigned stall_left;
      int unsigned seen_rsp;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left = 0;
         seen_rsp   = 0;
      end else begin
         if (seen_rsp != rsp_cnt) begin
            seen_rsp   = rsp_cnt;
            stall_left = (rsp_burst || $urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 17);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : monitor
      selection_type got;
      selection_type want;
      int unsigned   bad;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            expected_selections.push_back(next_selection(req_if.restart));
            if (req_if.restart) n_restarts++;
            taken_cnt++;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            got.pos = {rsp_if.pos7, rsp_if.pos6, rsp_if.pos5, rsp_if.pos4,
                       rsp_if.pos3, rsp_if.pos2, rsp_if.pos1, rsp_if.pos0};
            got.is_final  = rsp_if.is_final;
            got.exhausted = rsp_if.exhausted;
            rsp_cnt++;
            if (expected_selections.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: response with no request outstanding: pos=%h final=%b exh=%b",
                           $realtime, got.pos, got.is_final, got.exhausted);
            end else begin
               want = expected_selections.pop_front();
               bad  = 0;
               for (int j = 0; j < kperm_pkg::NUM_POS; j++)
                  if (got.pos[j] !== want.pos[j]) bad++;
               if (got.is_final !== want.is_final) bad++;
               if (got.exhausted !== want.exhausted) bad++;
               if (bad != 0) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"%0t: response %0d: expected pos=%h final=%b exh=%b,",
                               " got pos=%h final=%b exh=%b"},
                              $realtime, rsp_cnt, want.pos, want.is_final, want.exhausted,
                              got.pos, got.is_final, got.exhausted);
               end
               if (want.is_final) n_final++;
               if (want.exhausted) n_exhausted++;
            end
         end
      end
   end

   task automatic send(int unsigned cnt, logic restart);
      req_item_type it;
      @(posedge clock);
      repeat (cnt) begin
         it.restart = restart;
         it.gap     = (req_burst || $urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 17);
         pending_requests.push_back(it);
      end
   endtask

   task automatic wait_idle();
      while (!(pending_requests.size() == 0 && taken_cnt == issued_cnt &&
               expected_selections.size() == 0))
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(kperm_pkg::csr_reg_type idx, logic [3:0] data);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      if (idx == kperm_pkg::REG_VALUE_COUNT) n_reg = data;
      else m_reg = data;
      have_started = 1'b0;
      at_last      = 1'b0;
      n_writes++;
   endtask

   initial begin : stimulus
      int unsigned pick;
      int unsigned w;
      int unsigned n_eff;
      int unsigned m_eff;
      int unsigned n_perm;
      int unsigned len;
      int unsigned restart_pct;
      logic [3:0]  nv;
      logic [3:0]  mv;
      reset          = 1'b1;
      csr_wr_en      = 1'b0;
      csr_index      = '0;
      csr_wr_data    = '0;
      req_if.valid   = 1'b0;
      req_if.restart = 1'b0;
      rsp_if.ready   = 1'b0;
      n_reg          = kperm_pkg::COUNT_RESET;
      m_reg          = kperm_pkg::COUNT_RESET;
      used_mask      = '0;
      have_started   = 1'b0;
      at_last        = 1'b0;
      foreach (sel_state[j]) sel_state[j] = '0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // reset values: next before any start, restart, then one step
      send(1, 1'b0);
      send(1, 1'b1);
      send(1, 1'b0);
      wait_idle();
      // 3 of 3: walk to the final selection and past it
      write_reg(kperm_pkg::REG_VALUE_COUNT, 4'd3);
      write_reg(kperm_pkg::REG_PICK_COUNT, 4'd3);
      send(1, 1'b1);
      send(1, 1'b0);
      wait_idle();
      write_reg(kperm_pkg::REG_VALUE_COUNT, 4'd3);
      send(8, 1'b0);
      send(1, 1'b1);
      wait_idle();
      // empty selection length
      write_reg(kperm_pkg::REG_PICK_COUNT, 4'd0);
      send(1, 1'b0);
      send(1, 1'b1);
      wait_idle();
      // length larger than value range
      write_reg(kperm_pkg::REG_VALUE_COUNT, 4'd2);
      write_reg(kperm_pkg::REG_PICK_COUNT, 4'd5);
      send(1, 1'b0);
      wait_idle();
      // oversized registers clamp
      write_reg(kperm_pkg::REG_VALUE_COUNT, 4'd15);
      write_reg(kperm_pkg::REG_PICK_COUNT, 4'd15);
      send(1, 1'b1);
      send(1, 1'b0);
      wait_idle();
      write_reg(kperm_pkg::REG_VALUE_COUNT, 4'd1);
      write_reg(kperm_pkg::REG_PICK_COUNT, 4'd1);
      send(2, 1'b0);
      send(1, 1'b1);
      wait_idle();

      while (random_items < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 9);
         if (pick <= 5) begin
            nv = 4'($urandom_range(1, 5));
            mv = 4'($urandom_range(1, nv));
         end else if (pick == 6) begin
            nv = 4'($urandom_range(6, 8));
            mv = 4'($urandom_range(1, 3));
         end else begin
            nv = 4'($urandom_range(0, 15));
            mv = 4'($urandom_range(0, 15));
         end
         w = $urandom_range(0, 5);
         if (w == 1 || w >= 3) write_reg(kperm_pkg::REG_VALUE_COUNT, nv);
         if (w == 2 || w >= 3) write_reg(kperm_pkg::REG_PICK_COUNT, mv);
         n_eff = (n_reg > kperm_pkg::NUM_POS) ? kperm_pkg::NUM_POS : n_reg;
         m_eff = (m_reg > kperm_pkg::NUM_POS) ? kperm_pkg::NUM_POS : m_reg;
         if (m_eff == 0 || m_eff > n_eff) begin
            len = $urandom_range(2, 6);
         end else begin
            n_perm = 1;
            for (int unsigned i = 0; i < m_eff; i++) n_perm *= n_eff - i;
            len = ((n_perm <= 120) ? n_perm : $urandom_range(30, 120)) + $urandom_range(1, 12);
         end
         if (random_items + len > RANDOM_ITEMS) len = RANDOM_ITEMS - random_items;
         restart_pct = ($urandom_range(0, 1) == 0) ? 0 : 5;
         req_burst   = ($urandom_range(0, 3) == 0);
         rsp_burst   = ($urandom_range(0, 3) == 0);
         @(posedge clock);
         repeat (len) begin
            send(0, 1'b0);
            pending_requests.push_back('{restart: ($urandom_range(0, 99) < restart_pct),
                                         gap: (req_burst || $urandom_range(0, 1) == 0) ?
                                              0 : $urandom_range(0, 17)});
         end
         random_items += len;
         wait_idle();
      end

      repeat (40) @(negedge clock);
      $display("ran %0d requests (%0d restarts) over %0d register writes",
               taken_cnt, n_restarts, n_writes);
      $display("checked %0d responses: %0d final selections, %0d exhausted, %0d mismatches",
               rsp_cnt, n_final, n_exhausted, mismatches);
      if (mismatches == 0 && expected_selections.size() == 0 && taken_cnt == rsp_cnt)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
